// File: src/eqr_pkg.sv
// ---------------------------------------------------------------------------
// eqr_pkg: shared types and constants of the equipment replacement planner
// Field widths, transfer structs and register indexes.
// ---------------------------------------------------------------------------
package eqr_pkg;

   localparam int MAX_LIFE_DEF    = 32;
   localparam int MAX_HORIZON_DEF = 31;

   localparam int VAL_W      = 48;
   localparam int SUM_W      = 40;
   localparam int MONEY_W    = 30;
   localparam int PERIOD_W   = 5;
   localparam int MASK_W     = 32;
   localparam int COUNT_W    = 6;
   localparam int LIFE_REG_W = 6;
   localparam int HOR_REG_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 30;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRICE   = 2'd0,
      CSR_LIFE    = 2'd1,
      CSR_HORIZON = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [MONEY_W-1:0] resale_value;
      logic [MONEY_W-1:0] upkeep_cost;
   } req_item_type;

   typedef struct packed {
      logic [PERIOD_W-1:0]    period;
      logic signed [VAL_W-1:0] min_cost;
      logic signed [VAL_W-1:0] profit;
      logic [PERIOD_W-1:0]    next_year;
      logic [MASK_W-1:0]      tie_mask;
      logic [COUNT_W-1:0]     tie_count;
      logic                   last;
   } rsp_item_type;

endpackage

// File: src/equipment_replacement_dp.sv
// ---------------------------------------------------------------------------
// equipment_replacement_dp: equipment replacement planner
// Loads keep-cost rows, then solves the replacement recursion backward.
// ---------------------------------------------------------------------------
// A row transfer is taken when start is high and busy is low; each row holds
// busy for one cycle while its keep cost is written to the cost memory, so no
// new row is taken before that write. The row that completes the lifetime
// set starts the solve: one terminal result, then one result per period t
// once span = min(horizon-t, lifetime) candidates have passed the single
// add/compare pipeline that walks one candidate year per cycle through the
// two cost memories. Results leave on rsp_strobe for one cycle each, horizon
// first, period zero last with last set; the receiver cannot stall, and busy
// falls in the cycle that shows the period zero result.
module equipment_replacement_dp
   import eqr_pkg::*;
#(
   parameter int MAX_LIFE    = MAX_LIFE_DEF,
   parameter int MAX_HORIZON = MAX_HORIZON_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_data,
   output logic                  rsp_strobe,
   output rsp_item_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LIFE_W = $clog2(MAX_LIFE + 1);
   localparam int KIDX_W = (MAX_LIFE > 1) ? $clog2(MAX_LIFE) : 1;
   localparam int HOR_W  = $clog2(MAX_HORIZON + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_WRITE = 5'b00010,
      S_START = 5'b00100,
      S_SOLVE = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [MONEY_W-1:0]    price_ff;
   logic [LIFE_REG_W-1:0] life_cfg_ff;
   logic [HOR_REG_W-1:0]  hor_cfg_ff;

   logic [LIFE_W-1:0] eff_life;
   logic [HOR_W-1:0]  eff_hor;

   logic [LIFE_W-1:0]       rows_ff;
   logic [LIFE_W-1:0]       rows_after;
   logic [SUM_W-1:0]        sum_ff;
   logic signed [VAL_W-1:0] base_ff;
   logic                    load_en_ff;

   logic signed [VAL_W-1:0] keep_mem [MAX_LIFE];
   logic signed [VAL_W-1:0] best_mem [MAX_HORIZON + 1];

   logic [HOR_W-1:0]        t_ff, t_nxt;
   logic [HOR_W-1:0]        diff_nxt;
   logic [LIFE_W-1:0]       span_ff, span_nxt;
   logic [LIFE_W-1:0]       iss_ff;
   logic                    issue;
   logic [HOR_W-1:0]        best_addr;
   logic                    rd_vld_ff;
   logic [KIDX_W-1:0]       rd_x_ff;
   logic signed [VAL_W-1:0] keep_q_ff, best_q_ff;
   logic                    sum_vld_ff;
   logic [KIDX_W-1:0]       sum_x_ff;
   logic signed [VAL_W-1:0] cand_ff;
   logic signed [VAL_W-1:0] best_ff;
   logic [KIDX_W-1:0]       best_off_ff;
   logic [MASK_W-1:0]       mask_ff;
   logic [COUNT_W-1:0]      cnt_ff;

   logic                    best_we;
   logic [HOR_W-1:0]        best_wa;
   logic signed [VAL_W-1:0] best_wd;

   logic                    rsp_strobe_ff;
   rsp_item_type            rsp_data_ff;

   logic accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      if (life_cfg_ff == '0) begin
         eff_life = LIFE_W'(1);
      end else if (32'(life_cfg_ff) > 32'(MAX_LIFE)) begin
         eff_life = LIFE_W'(MAX_LIFE);
      end else begin
         eff_life = LIFE_W'(life_cfg_ff);
      end
      if (32'(hor_cfg_ff) > 32'(MAX_HORIZON)) begin
         eff_hor = HOR_W'(MAX_HORIZON);
      end else begin
         eff_hor = HOR_W'(hor_cfg_ff);
      end
   end

   assign rows_after = load_en_ff ? LIFE_W'(32'(rows_ff) + 1) : rows_ff;

   // next period and its candidate window
   always_comb begin
      t_nxt    = (state_ff == S_START) ? HOR_W'(eff_hor - 1'b1) : HOR_W'(t_ff - 1'b1);
      diff_nxt = HOR_W'(eff_hor - t_nxt);
      if (32'(diff_nxt) > 32'(eff_life)) begin
         span_nxt = eff_life;
      end else begin
         span_nxt = LIFE_W'(diff_nxt);
      end
   end

   assign issue     = (state_ff == S_SOLVE) && (iss_ff < span_ff);
   assign best_addr = HOR_W'(32'(t_ff) + 32'(iss_ff) + 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_WRITE;
         end
         S_WRITE: begin
            state_in = (rows_after >= eff_life) ? S_START : S_IDLE;
         end
         S_START: begin
            state_in = (eff_hor == '0) ? S_IDLE : S_SOLVE;
         end
         S_SOLVE: begin
            if (!issue && !rd_vld_ff && !sum_vld_ff) state_in = S_EMIT;
         end
         S_EMIT: begin
            state_in = (t_ff == '0) ? S_IDLE : S_SOLVE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         price_ff    <= MONEY_W'(1);
         life_cfg_ff <= LIFE_REG_W'(1);
         hor_cfg_ff  <= HOR_REG_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PRICE:   price_ff    <= csr_wdata[MONEY_W-1:0];
            CSR_LIFE:    life_cfg_ff <= csr_wdata[LIFE_REG_W-1:0];
            CSR_HORIZON: hor_cfg_ff  <= csr_wdata[HOR_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rows_ff       <= '0;
         sum_ff        <= '0;
         load_en_ff    <= 1'b0;
         rd_vld_ff     <= 1'b0;
         sum_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= issue;
         sum_vld_ff    <= rd_vld_ff;
         rsp_strobe_ff <= (state_ff == S_START) || (state_ff == S_EMIT);
         if (accept) begin
            load_en_ff <= (32'(rows_ff) < 32'(MAX_LIFE));
            if (32'(rows_ff) < 32'(MAX_LIFE)) begin
               sum_ff <= sum_ff + SUM_W'(req_data.upkeep_cost);
            end
         end
         if (state_ff == S_WRITE) begin
            if (rows_after >= eff_life) begin
               rows_ff <= '0;
               sum_ff  <= '0;
            end else begin
               rows_ff <= rows_after;
            end
         end
      end
   end

   // row datapath and keep-cost memory
   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff <= $signed({{(VAL_W-MONEY_W){1'b0}}, price_ff})
                  - $signed({{(VAL_W-MONEY_W){1'b0}}, req_data.resale_value});
      end
      if ((state_ff == S_WRITE) && load_en_ff) begin
         keep_mem[rows_ff[KIDX_W-1:0]] <= base_ff + $signed({{(VAL_W-SUM_W){1'b0}}, sum_ff});
      end
      keep_q_ff <= keep_mem[iss_ff[KIDX_W-1:0]];
   end

   always_comb begin
      best_we = 1'b0;
      best_wa = t_ff;
      best_wd = best_ff;
      if (state_ff == S_START) begin
         best_we = 1'b1;
         best_wa = eff_hor;
         best_wd = '0;
      end else if (state_ff == S_EMIT) begin
         best_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (best_we) begin
         best_mem[best_wa] <= best_wd;
      end
      best_q_ff <= best_mem[best_addr];
   end

   // candidate pipeline: read, add, compare
   always_ff @(posedge clock) begin
      rd_x_ff  <= iss_ff[KIDX_W-1:0];
      sum_x_ff <= rd_x_ff;
      cand_ff  <= keep_q_ff + best_q_ff;
      if (issue) begin
         iss_ff <= LIFE_W'(32'(iss_ff) + 1);
      end
      if (((state_ff == S_START) && (eff_hor != '0))
          || ((state_ff == S_EMIT) && (t_ff != '0))) begin
         t_ff    <= t_nxt;
         span_ff <= span_nxt;
         iss_ff  <= '0;
         mask_ff <= '0;
         cnt_ff  <= '0;
      end
      if (sum_vld_ff) begin
         if ((sum_x_ff == '0) || (cand_ff < best_ff)) begin
            best_ff     <= cand_ff;
            best_off_ff <= sum_x_ff;
            mask_ff     <= MASK_W'(1) << sum_x_ff;
            cnt_ff      <= COUNT_W'(1);
         end else if (cand_ff == best_ff) begin
            mask_ff <= mask_ff | (MASK_W'(1) << sum_x_ff);
            cnt_ff  <= COUNT_W'(cnt_ff + 1'b1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == S_START) begin
         rsp_data_ff.period    <= PERIOD_W'(eff_hor);
         rsp_data_ff.min_cost  <= '0;
         rsp_data_ff.profit    <= $signed({{(VAL_W-MONEY_W){1'b0}}, price_ff});
         rsp_data_ff.next_year <= PERIOD_W'(eff_hor);
         rsp_data_ff.tie_mask  <= '0;
         rsp_data_ff.tie_count <= '0;
         rsp_data_ff.last      <= (eff_hor == '0);
      end else if (state_ff == S_EMIT) begin
         rsp_data_ff.period    <= PERIOD_W'(t_ff);
         rsp_data_ff.min_cost  <= best_ff;
         rsp_data_ff.profit    <= $signed({{(VAL_W-MONEY_W){1'b0}}, price_ff}) - best_ff;
         rsp_data_ff.next_year <= PERIOD_W'(32'(t_ff) + 32'(best_off_ff) + 1);
         rsp_data_ff.tie_mask  <= mask_ff;
         rsp_data_ff.tie_count <= cnt_ff;
         rsp_data_ff.last      <= (t_ff == '0);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: src/eqr_checker.sv
// ---------------------------------------------------------------------------
// eqr_checker: port-level checks for the equipment replacement planner
// Busy and result-strobe relations, attached to the top level by bind.
// ---------------------------------------------------------------------------
module eqr_checker
   import eqr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_strobe,
   input rsp_item_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("row transfer did not raise busy");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> !busy)
      else $error("busy still high with final result");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy)
      else $error("non-final result while idle");

   a_tie_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.tie_count == '0) == (rsp_data.tie_mask == '0)))
      else $error("tie count and tie mask disagree");

endmodule

bind equipment_replacement_dp eqr_checker u_eqr_checker (.*);

// File: tb/sv/equipment_replacement_dp_tb.sv
// ---------------------------------------------------------------------------
// equipment_replacement_dp_tb: self-checking bench of the replacement planner
// Feeds age rows and register writes from a queue, predicts every period
// result of each solve and compares the result transfers field by field.
// ---------------------------------------------------------------------------
module equipment_replacement_dp_tb;
   import eqr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [MONEY_W-1:0]   MONEY_MAX     = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE     = 2'd3;
   localparam int                   SETTLE_CYCLES = 4;
   localparam int                   TAIL_CYCLES   = 40;
   localparam int                   ROW_TARGET    = 370;

   typedef enum logic [1:0] {
      FEED_ROW,
      FEED_CSR,
      FEED_DRAIN
   } feed_kind_type;

   typedef struct {
      feed_kind_type           kind;
      logic [CSR_IDX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]   value;
      req_item_type            row;
   } feed_entry_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_item_type          req_data  = '0;
   logic                  rsp_strobe;
   rsp_item_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   equipment_replacement_dp i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // pending stimulus and the period results still owed by the block
   feed_entry_type row_feed[$];
   rsp_item_type   period_results_due[$];

   // planner state as seen from outside
   logic [MONEY_W-1:0]      price_cfg;
   logic [LIFE_REG_W-1:0]   life_cfg;
   logic [HOR_REG_W-1:0]    horizon_cfg;
   logic signed [VAL_W-1:0] keep_cost [MAX_LIFE_DEF];
   logic signed [VAL_W-1:0] best_cost [MAX_HORIZON_DEF+1];
   logic [SUM_W-1:0]        upkeep_sum;
   int                      rows_held;

   int mismatches      = 0;
   int rows_taken      = 0;
   int plans_done      = 0;
   int results_checked = 0;
   int csr_writes      = 0;

   // generator side bookkeeping, mirrors only the row count of a set
   int rows_fed   = 0;
   int gen_life   = 1;
   int gen_loaded = 0;

   function automatic int keep_life_eff();
      if (life_cfg == 0) return 1;
      if (life_cfg > MAX_LIFE_DEF) return MAX_LIFE_DEF;
      return int'(life_cfg);
   endfunction

   function automatic int horizon_eff();
      if (horizon_cfg > MAX_HORIZON_DEF) return MAX_HORIZON_DEF;
      return int'(horizon_cfg);
   endfunction

   task automatic solve_plan();
      int                      hor;
      int                      life;
      int                      span;
      int                      best_x;
      int                      ties;
      logic signed [VAL_W-1:0] best;
      logic signed [VAL_W-1:0] cand;
      logic [MASK_W-1:0]       ties_mask;
      rsp_item_type            res;
      hor  = horizon_eff();
      life = keep_life_eff();
      best_cost[hor] = '0;
      res           = '0;
      res.period    = PERIOD_W'(hor);
      res.profit    = VAL_W'(price_cfg);
      res.next_year = PERIOD_W'(hor);
      res.last      = (hor == 0);
      period_results_due.push_back(res);
      for (int t = hor - 1; t >= 0; t--) begin
         span = (hor - t < life) ? hor - t : life;
         best = '0;
         best_x = 0;
         ties = 0;
         ties_mask = '0;
         for (int x = 1; x <= span; x++) begin
            cand = keep_cost[x-1] + best_cost[t+x];
            if (x == 1 || cand < best) begin
               best = cand;
               best_x = t + x;
            end
         end
         for (int x = 1; x <= span; x++) begin
            cand = keep_cost[x-1] + best_cost[t+x];
            if (cand == best) begin
               ties_mask[x-1] = 1'b1;
               ties++;
            end
         end
         best_cost[t]  = best;
         res.period    = PERIOD_W'(t);
         res.min_cost  = best;
         res.profit    = VAL_W'(price_cfg) - best;
         res.next_year = PERIOD_W'(best_x);
         res.tie_mask  = ties_mask;
         res.tie_count = COUNT_W'(ties);
         res.last      = (t == 0);
         period_results_due.push_back(res);
      end
   endtask

   task automatic take_row(input req_item_type row);
      if (rows_held < MAX_LIFE_DEF) begin
         upkeep_sum = upkeep_sum + SUM_W'(row.upkeep_cost);
         keep_cost[rows_held] = VAL_W'(price_cfg) + VAL_W'(upkeep_sum)
                                - VAL_W'(row.resale_value);
         rows_held++;
      end
      if (rows_held >= keep_life_eff()) begin
         solve_plan();
         rows_held  = 0;
         upkeep_sum = '0;
      end
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
         mismatches++;
      end
   endfunction

   // monitor: register writes, result transfers, row transfers
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         price_cfg   = 1;
         life_cfg    = 1;
         horizon_cfg = 1;
         upkeep_sum  = '0;
         rows_held   = 0;
         period_results_due.delete();
      end else begin
         if (csr_we) begin
            csr_writes++;
            case (csr_index)
               CSR_PRICE:   price_cfg   = MONEY_W'(csr_wdata);
               CSR_LIFE:    life_cfg    = LIFE_REG_W'(csr_wdata);
               CSR_HORIZON: horizon_cfg = HOR_REG_W'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (period_results_due.size() == 0) begin
               $error("result transfer for period %0d with none expected", rsp_data.period);
               mismatches++;
            end else begin
               want = period_results_due.pop_front();
               check_field("period", want.period, rsp_data.period);
               check_field("min_cost", want.min_cost, rsp_data.min_cost);
               check_field("profit", want.profit, rsp_data.profit);
               check_field("next_year", want.next_year, rsp_data.next_year);
               check_field("tie_mask", want.tie_mask, rsp_data.tie_mask);
               check_field("tie_count", want.tie_count, rsp_data.tie_count);
               check_field("last", want.last, rsp_data.last);
               results_checked++;
               if (want.last) plans_done++;
            end
         end
         if (start && !busy) begin
            rows_taken++;
            take_row(req_data);
         end
      end
   end

   // driver: rows in bursts, register writes and drains only when idle
   int burst_left = 1;
   int gap_left   = 0;
   int idle_run   = 0;

   always @(posedge clock) begin
      logic drive_start;
      logic drive_we;
      drive_start = 1'b0;
      drive_we    = 1'b0;
      if (reset) begin
         burst_left = $urandom_range(1, 12);
         gap_left   = 0;
         idle_run   = 0;
      end else begin
         if (start && !busy) row_feed.delete(0);
         if (start && busy) begin
            drive_start = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (row_feed.size() > 0) begin
            if (row_feed[0].kind == FEED_ROW) begin
               drive_start = 1'b1;
               req_data <= row_feed[0].row;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  case ($urandom_range(0, 3))
                     0: gap_left = 0;
                     1: gap_left = $urandom_range(0, 40);
                     default: gap_left = $urandom_range(0, 4);
                  endcase
               end
            end else begin
               idle_run = (period_results_due.size() == 0 && !busy && !start) ?
                          idle_run + 1 : 0;
               if (idle_run >= SETTLE_CYCLES) begin
                  if (row_feed[0].kind == FEED_CSR) begin
                     drive_we = 1'b1;
                     csr_index <= row_feed[0].index;
                     csr_wdata <= row_feed[0].value;
                  end
                  row_feed.delete(0);
                  idle_run = 0;
               end
            end
         end
      end
      start  <= drive_start;
      csr_we <= drive_we;
   end

   task automatic feed_row(input logic [MONEY_W-1:0] resale, input logic [MONEY_W-1:0] upkeep);
      feed_entry_type e;
      e = '{kind: FEED_ROW, index: '0, value: '0, row: '{resale, upkeep}};
      row_feed.push_back(e);
      rows_fed++;
      gen_loaded++;
      if (gen_loaded >= gen_life) gen_loaded = 0;
   endtask

   task automatic feed_csr(input logic [CSR_IDX_W-1:0] index,
                           input logic [CSR_DATA_W-1:0] value);
      feed_entry_type e;
      int             life;
      e = '{kind: FEED_CSR, index: index, value: value, row: '0};
      row_feed.push_back(e);
      if (index == CSR_LIFE) begin
         life = int'(value[LIFE_REG_W-1:0]);
         gen_life = (life == 0) ? 1 : (life > MAX_LIFE_DEF) ? MAX_LIFE_DEF : life;
      end
   endtask

   task automatic feed_drain();
      feed_entry_type e;
      e = '{kind: FEED_DRAIN, index: '0, value: '0, row: '0};
      row_feed.push_back(e);
   endtask

   function automatic logic [MONEY_W-1:0] random_price();
      case ($urandom_range(0, 4))
         0: return MONEY_MAX;
         1: return 1;
         2: return MONEY_W'($urandom_range(0, 1000));
         default: return MONEY_W'($urandom());
      endcase
   endfunction

   function automatic logic [MONEY_W-1:0] row_value(input int mode);
      case (mode)
         0: return MONEY_W'($urandom());
         1: return MONEY_W'($urandom_range(0, 3));
         2: return $urandom_range(0, 1) ? MONEY_MAX : '0;
         default: return MONEY_W'($urandom_range(0, 1000000));
      endcase
   endfunction

   task automatic feed_random_set(input bit long_set);
      int                 mode;
      int                 v;
      logic [MONEY_W-1:0] noise;
      noise = MONEY_W'($urandom());
      if (long_set) begin
         feed_csr(CSR_LIFE, (noise & ~MONEY_W'(63)) | MONEY_W'($urandom_range(32, 63)));
         feed_csr(CSR_HORIZON, 31);
      end else begin
         if ($urandom_range(0, 1)) feed_csr(CSR_PRICE, random_price());
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 15))
               0: v = 0;
               1: v = $urandom_range(33, 63);
               2, 3: v = $urandom_range(7, MAX_LIFE_DEF);
               default: v = $urandom_range(1, 6);
            endcase
            feed_csr(CSR_LIFE, (noise & ~MONEY_W'(63)) | MONEY_W'(v));
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
               0: v = 0;
               1: v = 31;
               2: v = $urandom_range(0, 31);
               default: v = $urandom_range(1, 8);
            endcase
            feed_csr(CSR_HORIZON, (noise & ~MONEY_W'(31)) | MONEY_W'(v));
         end
         if ($urandom_range(0, 19) == 0) feed_csr(CSR_SPARE, MONEY_W'($urandom()));
      end
      mode = $urandom_range(0, 3);
      do begin
         if (!long_set && gen_loaded > 0 && $urandom_range(0, 9) == 0) begin
            // lifetime cut to at most the rows held, or a price change mid set
            if ($urandom_range(0, 1)) begin
               feed_csr(CSR_LIFE, CSR_DATA_W'($urandom_range(1, gen_loaded)));
            end else begin
               feed_csr(CSR_PRICE, random_price());
            end
         end
         feed_row(row_value(mode), row_value(mode));
      end while (gen_loaded != 0);
   endtask

   initial begin
      int wait_cycles;
      // reset values: one row, two periods
      feed_row(0, 0);
      feed_csr(CSR_PRICE, MONEY_MAX);
      feed_csr(CSR_LIFE, 3);
      feed_csr(CSR_HORIZON, 31);
      feed_row(MONEY_MAX, MONEY_MAX);
      feed_row(0, MONEY_MAX);
      feed_row(MONEY_MAX, 0);
      // lifetime zero and horizon zero, upper data bits set
      feed_csr(CSR_LIFE, 30'h3FFFFFC0);
      feed_csr(CSR_HORIZON, 30'h3FFFFFE0);
      feed_row(0, 0);
      feed_row(MONEY_MAX, MONEY_MAX);
      feed_csr(CSR_SPARE, MONEY_MAX);
      // all keep costs equal: ties everywhere
      feed_csr(CSR_PRICE, 100);
      feed_csr(CSR_LIFE, 3);
      feed_csr(CSR_HORIZON, 6);
      feed_row(100, 0);
      feed_row(100, 0);
      feed_row(100, 0);
      // negative keep costs, lifetime beyond the horizon
      feed_csr(CSR_PRICE, 1);
      feed_csr(CSR_LIFE, 4);
      feed_csr(CSR_HORIZON, 2);
      feed_row(1000, 5);
      feed_row(MONEY_MAX, 1);
      feed_row(7, 7);
      feed_row(0, 0);
      // lifetime lowered during loading
      feed_csr(CSR_PRICE, 500);
      feed_csr(CSR_LIFE, 6);
      feed_csr(CSR_HORIZON, 8);
      feed_row(10, 20);
      feed_row(30, 40);
      feed_row(50, 60);
      feed_csr(CSR_LIFE, 2);
      feed_row(70, 80);
      // price changed during loading
      feed_csr(CSR_PRICE, 9);
      feed_csr(CSR_LIFE, 3);
      feed_csr(CSR_HORIZON, 4);
      feed_row(1, 2);
      feed_csr(CSR_PRICE, 7);
      feed_row(3, 4);
      feed_row(5, 6);

      feed_random_set(1'b1);
      while (rows_fed < ROW_TARGET) begin
         feed_random_set($urandom_range(0, 24) == 0);
         if ($urandom_range(0, 5) == 0) feed_drain();
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (row_feed.size() != 0 || start) @(posedge clock);
      wait_cycles = 0;
      while ((period_results_due.size() != 0 || busy) && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (period_results_due.size() != 0) begin
         $error("%0d period results never arrived", period_results_due.size());
         mismatches++;
      end

      $display("summary: %0d row transfers, %0d register writes, %0d plans solved",
               rows_taken, csr_writes, plans_done);
      $display("summary: %0d period results checked, %0d mismatches",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
src/eqr_pkg.sv
src/equipment_replacement_dp.sv
src/eqr_checker.sv
tb/sv/equipment_replacement_dp_tb.sv
